### sv/idpr_pkg.sv
// ----------------------------------------------------------------------------
// idpr_pkg: shared types and constants for isolated dark pixel removal
// Sizes of the line memory, result and burst records, config indexes.
// ----------------------------------------------------------------------------
package idpr_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ROW_LIMIT = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(ROW_LIMIT);
  localparam int POS_W     = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 24;
  localparam int WORD_W    = PIX_W + 1;
  localparam int BURST_MAX = 3;
  localparam int CNT_W     = 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int LVL_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  localparam logic [PIX_W-1:0] WHITE_PIX = 24'hFF_FFFF;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } result_t;

  typedef struct packed {
    result_t [BURST_MAX-1:0] slot;
    logic [CNT_W-1:0]        cnt;
  } burst_t;

  function automatic logic is_dark(input logic [PIX_W-1:0] p);
    return p[7:0] == 8'd0;
  endfunction

  // Replace a dark pixel by white when no neighbor is dark
  function automatic logic [PIX_W-1:0] clean_pix(input logic [PIX_W-1:0] p,
                                                  input logic nb);
    return (is_dark(p) && !nb) ? WHITE_PIX : p;
  endfunction

endpackage

### sv/idpr_ram.sv
// ----------------------------------------------------------------------------
// idpr_ram: generic synchronous RAM
// One write port, two read ports, registered read data (old data on a
// read of the address being written).
// ----------------------------------------------------------------------------
module idpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/idpr_burst_q.sv
// ----------------------------------------------------------------------------
// idpr_burst_q: result burst queue
// Holds up to QDEPTH bursts of one to three results and hands them out one
// result per cycle while out_ready holds, marking each burst's last result.
// ----------------------------------------------------------------------------
module idpr_burst_q (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_v,
  input  idpr_pkg::burst_t        push_burst,
  output logic [idpr_pkg::LVL_W-1:0] level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output idpr_pkg::result_t       out_res,
  output logic                    out_last
);
  import idpr_pkg::*;

  burst_t             bq_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, wr_nxt;
  logic [QPTR_W-1:0]  rd_r, rd_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  burst_t             head;
  logic               pop;
  logic               pop_last;

  assign head      = bq_r[rd_r];
  assign out_valid = (lvl_r != '0);
  assign out_res   = head.slot[idx_r];
  assign out_last  = (idx_r == head.cnt - CNT_W'(1));
  assign level     = lvl_r;

  assign pop      = out_valid && out_ready;
  assign pop_last = pop && out_last;

  always_comb begin
    wr_nxt  = push_v ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop_last ? rd_r + QPTR_W'(1) : rd_r;
    lvl_nxt = lvl_r + LVL_W'(push_v) - LVL_W'(pop_last);
    if (pop_last) begin
      idx_nxt = '0;
    end else if (pop) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
      idx_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      lvl_r <= lvl_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_v) begin
      bq_r[wr_r] <= push_burst;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_v |-> (lvl_r < LVL_W'(QDEPTH)))
    else $error("burst pushed into a full queue");

  a_no_empty_burst: assert property (@(posedge clk) disable iff (!rst_n)
    push_v |-> (push_burst.cnt != '0))
    else $error("empty burst pushed");

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < head.cnt))
    else $error("result index beyond burst length");
`endif

endmodule

### sv/isolated_dark_pixel_removal.sv
// ----------------------------------------------------------------------------
// isolated_dark_pixel_removal: 4-connected isolated dark pixel filter
// Raster RGB stream in, filtered pixels with row/column positions out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output keeps up. Each pixel is read
// against one line memory (previous row's pixels plus the dark flags of the
// row above it) with a two-port read in the accept cycle and a write-back the
// cycle after. That round trip puts a pixel's results into the output queue
// in the cycle after acceptance, and the queue registers them before the
// first can leave. Results leave one per clock while out_ready holds. Above
// the last row a pixel completes at most one result. On the last row a pixel
// completes up to two, and the last pixel of the frame up to three, so once
// the queue has filled a last row takes input only as fast as results drain.
// Input is held back while the four-burst output queue, counting the pixel in
// the second stage, has no room for another burst. The line memory needs no
// clearing pass: the row checks mask what a row reads before it is written.
// A configuration write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module isolated_dark_pixel_removal (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [idpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [idpr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_pixel_red,
  input  logic [7:0]                      in_pixel_green,
  input  logic [7:0]                      in_pixel_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [idpr_pkg::POS_W-1:0]      out_row,
  output logic [idpr_pkg::POS_W-1:0]      out_col,
  output logic                            out_last_in_burst
);
  import idpr_pkg::*;

  localparam int WEXT_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 2;
  localparam int HEXT_W = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 2;

  // configuration and position
  logic [CFG_W-1:0]  width_r, height_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [WEXT_W-1:0] w_ext;
  logic [HEXT_W-1:0] h_ext;
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic              last_col, last_row;
  logic              accept;
  logic [PIX_W-1:0]  cur_in;
  logic [COL_W-1:0]  ra1;

  // second stage
  logic              s1_v_r;
  logic [PIX_W-1:0]  s1_cur_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic              s1_lcol_r, s1_lrow_r;
  logic              fwd0_r, fwd1_r;
  logic [WORD_W-1:0] fwd_word_r;
  logic              left_dark_r;
  logic [PIX_W-1:0]  prev1_r;
  logic              prev2_dark_r;

  logic [WORD_W-1:0] rd0, rd1, word0, word1, wdata;
  logic [PIX_W-1:0]  p_up, p_right;
  logic              up_flag, pd, cd;
  logic              col_nz, col_gt1, row_nz, row_gt1;
  logic              nb1, nb2, nb3, v1, v2, v3;
  result_t           res1, res2, res3;
  burst_t            burst;
  logic              push_v;

  logic [LVL_W-1:0]  q_level;
  result_t           q_res;

  // ---- effective frame size ----
  always_comb begin
    w_ext = WEXT_W'(width_r);
    if (w_ext == '0) begin
      w_ext = WEXT_W'(1);
    end
    if (w_ext > WEXT_W'(MAX_WIDTH)) begin
      w_ext = WEXT_W'(MAX_WIDTH);
    end
    h_ext = HEXT_W'(height_r);
    if (h_ext == '0) begin
      h_ext = HEXT_W'(1);
    end
    if (h_ext > HEXT_W'(ROW_LIMIT)) begin
      h_ext = HEXT_W'(ROW_LIMIT);
    end
  end

  assign wm1      = COL_W'(w_ext - WEXT_W'(1));
  assign hm1      = ROW_W'(h_ext - HEXT_W'(1));
  assign last_col = (col_r == wm1);
  assign last_row = (row_r == hm1);

  assign in_ready = ((LVL_W + 1)'(q_level) + (LVL_W + 1)'(s1_v_r)) < (LVL_W + 1)'(QDEPTH);
  assign accept   = in_valid && in_ready;
  assign cur_in   = {in_pixel_red, in_pixel_green, in_pixel_blue};
  assign ra1      = col_r + COL_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
          CFG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= accept;
    end
  end

  // ---- line memory: {dark flag of row r-2, pixel of row r-1} per column ----
  idpr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .we      (s1_v_r),
    .waddr   (s1_col_r),
    .wdata   (wdata),
    .raddr_a (col_r),
    .rdata_a (rd0),
    .raddr_b (ra1),
    .rdata_b (rd1)
  );

  // stage-two payload and neighbor history
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r  <= cur_in;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_lcol_r <= last_col;
      s1_lrow_r <= last_row;
    end
    // forward the write-back that lands in the same cycle as the read
    fwd0_r     <= s1_v_r && (s1_col_r == col_r);
    fwd1_r     <= s1_v_r && (s1_col_r == ra1);
    fwd_word_r <= wdata;
    if (s1_v_r) begin
      left_dark_r  <= pd;
      prev1_r      <= s1_cur_r;
      prev2_dark_r <= is_dark(prev1_r);
    end
  end

  // ---- neighbor evaluation ----
  assign word0   = fwd0_r ? fwd_word_r : rd0;
  assign word1   = fwd1_r ? fwd_word_r : rd1;
  assign p_up    = word0[PIX_W-1:0];
  assign up_flag = word0[PIX_W];
  assign p_right = word1[PIX_W-1:0];
  assign pd      = is_dark(p_up);
  assign cd      = is_dark(s1_cur_r);
  assign wdata   = {pd, s1_cur_r};

  assign col_nz  = (s1_col_r != '0);
  assign col_gt1 = (s1_col_r > COL_W'(1));
  assign row_nz  = (s1_row_r != '0);
  assign row_gt1 = (s1_row_r > ROW_W'(1));

  always_comb begin
    // pixel above the incoming one
    v1       = row_nz;
    nb1      = cd || (row_gt1 && up_flag) || (col_nz && left_dark_r) ||
               (!s1_lcol_r && is_dark(p_right));
    res1.pix = clean_pix(p_up, nb1);
    res1.row = POS_W'(s1_row_r - ROW_W'(1));
    res1.col = POS_W'(s1_col_r);

    // last row: left neighbor of the incoming pixel
    v2       = s1_lrow_r && col_nz;
    nb2      = cd || (row_nz && left_dark_r) || (col_gt1 && prev2_dark_r);
    res2.pix = clean_pix(prev1_r, nb2);
    res2.row = POS_W'(s1_row_r);
    res2.col = POS_W'(s1_col_r - COL_W'(1));

    // last pixel of the frame: the incoming pixel itself
    v3       = s1_lrow_r && s1_lcol_r;
    nb3      = (row_nz && pd) || (col_nz && is_dark(prev1_r));
    res3.pix = clean_pix(s1_cur_r, nb3);
    res3.row = POS_W'(s1_row_r);
    res3.col = POS_W'(s1_col_r);

    // pack valid results toward slot 0
    burst.slot[0] = v1 ? res1 : (v2 ? res2 : res3);
    burst.slot[1] = (v1 && v2) ? res2 : res3;
    burst.slot[2] = res3;
    burst.cnt     = CNT_W'(v1) + CNT_W'(v2) + CNT_W'(v3);
  end

  assign push_v = s1_v_r && (v1 || v2 || v3);

  idpr_burst_q u_bq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_v     (push_v),
    .push_burst (burst),
    .level      (q_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (q_res),
    .out_last   (out_last_in_burst)
  );

  assign out_red   = q_res.pix[23:16];
  assign out_green = q_res.pix[15:8];
  assign out_blue  = q_res.pix[7:0];
  assign out_row   = q_res.row;
  assign out_col   = q_res.col;

`ifndef SYNTH
  a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(in_valid && in_ready))
    else $error("stage two active without an accepted item");

  a_frame_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_lrow_r && s1_lcol_r) |-> push_v)
    else $error("last pixel of frame produced no burst");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wm1)
    else $error("column counter beyond frame width");
`endif

endmodule
